[design/refcounted_cache_release_order_evict_macros.svh]
// Assertion macros for the release-order cache checker
`ifndef REFCOUNTED_CACHE_RELEASE_ORDER_EVICT_MACROS_SVH
`define REFCOUNTED_CACHE_RELEASE_ORDER_EVICT_MACROS_SVH
// implication checked on every edge outside reset
`define RC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/rcache_pkg.sv]
// ----------------------------------------------------------------------------
// rcache_pkg
// Types and constants shared by the release-order cache.
// ----------------------------------------------------------------------------
`default_nettype none
package rcache_pkg;
  localparam int CFG_W   = 42;
  localparam int TOTAL_W = 42;
  localparam int SIZE_W  = 38;
  localparam int BITS_W  = 40;
  localparam int CNT_W   = 31;
  localparam int STAMP_W = 32;
  localparam int KEYIN_W = 32;
  localparam int BASE_COST = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_INSERT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_REL = 1'b1;

  localparam logic [0:0] REG_SIZE_LIMIT = 1'd0;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       key;
    logic [BITS_W-1:0] object_bits;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot;
    logic [4:0]         evicted_count;
    logic [CNT_W-1:0]   refs_now;
    logic [TOTAL_W-1:0] total_size;
  } out_t;

  // cell operations driven by the sequencer
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_AGE    = 3'd2;
  localparam logic [2:0] OP_INVAL  = 3'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         target;
    logic               in_use;
    logic [STAMP_W-1:0] age;
    logic [SIZE_W-1:0]  size;
  } cell_cmd_t;

  // token travelling down the chain
  typedef struct packed {
    logic               hit;
    logic [7:0]         hit_idx;
    logic               hit_in_use;
    logic [STAMP_W-1:0] hit_age;
    logic               free;
    logic [7:0]         free_idx;
    logic               rel;
    logic [7:0]         rel_idx;
    logic [STAMP_W-1:0] rel_stamp;
    logic [SIZE_W-1:0]  rel_size;
  } token_t;
endpackage
`default_nettype wire

[design/refcounted_cache_release_order_evict.sv]
// Operation: with S = ENTRIES/4 rounded up token registers in the chain, a hit,
// release, unknown key or full table gives its result beat after one scan of
// the chain. An insert then evicts the oldest released entry, one scan each,
// while the total exceeds the size limit; a last scan that finds nothing ends it.
// One item at a time; the next beat is taken once the result beat is accepted.
// Reset: synchronous, clears all valid bits, total, stamp; limit all ones.
`default_nettype none
module refcounted_cache_release_order_evict #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire rcache_pkg::in_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output rcache_pkg::out_t   out_data,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [3:0]          paddr,
  input  wire [63:0]         pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import rcache_pkg::*;

  localparam int NSTG = (ENTRIES + 3) / 4;
  localparam int WW = $clog2(NSTG + 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EVIC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]          state;
  logic [WW-1:0]       wait_cnt;
  logic [CFG_W-1:0]    size_limit;
  logic [TOTAL_W-1:0]  total;
  logic [STAMP_W-1:0]  stamp;
  in_t                 req;
  out_t                res;
  cell_cmd_t           cmd;
  token_t              tok;
  logic [KEY_BITS-1:0] key;
  logic [4:0]          evicted;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [SIZE_W-1:0]   new_size;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_SIZE_LIMIT) ? 64'(size_limit) : 64'd0;
  assign key = KEY_BITS'(req.key);
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign new_size = SIZE_W'(BASE_COST) + SIZE_W'(req.object_bits >> 3);
  assign cnt = tok.hit_in_use ? tok.hit_age[CNT_W-1:0] : '0;

  always_comb begin
    if (cnt == '0) cnt_next = CNT_W'(1);
    else if (cnt == COUNT_MAX) cnt_next = COUNT_MAX;
    else cnt_next = cnt + CNT_W'(1);
  end

  rcache_chain #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_chain (
    .clk(clk), .rst(rst), .key(key), .cmd(cmd), .tok(tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      size_limit <= {CFG_W{1'b1}};
      total      <= '0;
      stamp      <= '0;
      wait_cnt   <= '0;
      cmd.op     <= OP_NONE;
    end else begin
      if (psel && penable && pwrite && paddr[3] == REG_SIZE_LIMIT)
        size_limit <= pwdata[CFG_W-1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cmd.op <= OP_NONE;
          if (in_valid && in_ready) begin
            req      <= in_data;
            wait_cnt <= '0;
            evicted  <= '0;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (wait_cnt == WW'(NSTG + 1)) begin
            if (req.cmd == CMD_GET) begin
              if (tok.hit) begin
                cmd.op <= OP_AGE; cmd.target <= tok.hit_idx; cmd.in_use <= 1'b1;
                cmd.age <= STAMP_W'(cnt_next);
                res <= '{status: ST_HIT, slot: tok.hit_idx[3:0], evicted_count: 5'd0,
                         refs_now: cnt_next, total_size: total};
                wait_cnt <= wait_cnt + WW'(1);
                state <= S_OUT;
              end else if (!tok.free) begin
                cmd.op <= OP_NONE;
                res <= '{status: ST_FULL, slot: 4'd0, evicted_count: 5'd0,
                         refs_now: '0, total_size: total};
                wait_cnt <= wait_cnt + WW'(1);
                state <= S_OUT;
              end else begin
                cmd.op <= OP_WRITE; cmd.target <= tok.free_idx;
                cmd.in_use <= 1'b1; cmd.age <= STAMP_W'(1);
                cmd.size <= new_size;
                total <= total + TOTAL_W'(new_size);
                res <= '{status: ST_INSERT, slot: tok.free_idx[3:0], evicted_count: 5'd0,
                         refs_now: CNT_W'(1), total_size: total};
                wait_cnt <= '0;
                state <= S_EVIC;
              end
            end else begin
              wait_cnt <= wait_cnt + WW'(1);
              state <= S_OUT;
              if (!tok.hit) begin
                cmd.op <= OP_NONE;
                res <= '{status: ST_UNKNOWN, slot: 4'd0, evicted_count: 5'd0,
                         refs_now: '0, total_size: total};
              end else if (tok.hit_in_use && tok.hit_age[CNT_W-1:0] > CNT_W'(1)) begin
                cmd.op <= OP_AGE; cmd.target <= tok.hit_idx; cmd.in_use <= 1'b1;
                cmd.age <= STAMP_W'(tok.hit_age[CNT_W-1:0] - CNT_W'(1));
                res <= '{status: ST_HIT, slot: tok.hit_idx[3:0], evicted_count: 5'd0,
                         refs_now: tok.hit_age[CNT_W-1:0] - CNT_W'(1), total_size: total};
              end else begin
                cmd.op <= OP_AGE; cmd.target <= tok.hit_idx; cmd.in_use <= 1'b0;
                cmd.age <= stamp + STAMP_W'(1);
                stamp <= stamp + STAMP_W'(1);
                res <= '{status: ST_HIT, slot: tok.hit_idx[3:0], evicted_count: 5'd0,
                         refs_now: '0, total_size: total};
              end
            end
          end else begin
            cmd.op <= OP_NONE;
            wait_cnt <= wait_cnt + WW'(1);
          end
        end
        S_EVIC: begin
          if (wait_cnt == '0) begin
            cmd.op <= OP_NONE;
            wait_cnt <= wait_cnt + WW'(1);
            res.total_size <= total;
            if (total <= size_limit) state <= S_OUT;
          end else if (wait_cnt == WW'(NSTG + 1)) begin
            wait_cnt <= '0;
            if (!tok.rel) begin
              cmd.op <= OP_NONE;
              state <= S_OUT;
            end else begin
              cmd.op <= OP_INVAL; cmd.target <= tok.rel_idx;
              total <= total - TOTAL_W'(tok.rel_size);
              evicted <= evicted + 5'd1;
              res.evicted_count <= evicted + 5'd1;
            end
          end else begin
            cmd.op <= OP_NONE;
            wait_cnt <= wait_cnt + WW'(1);
          end
        end
        S_OUT: begin
          cmd.op <= OP_NONE;
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          cmd.op <= OP_NONE;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[design/rcache_cell.sv]
// ----------------------------------------------------------------------------
// rcache_cell
// One table slot: holds key, age and size, and updates the passing token.
// ----------------------------------------------------------------------------
`default_nettype none
module rcache_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire [KEY_BITS-1:0]       key,
  input  wire rcache_pkg::cell_cmd_t cmd,
  input  wire [KEY_BITS-1:0]       wkey,
  input  wire rcache_pkg::token_t  tok_in,
  output rcache_pkg::token_t       tok_out
);
  import rcache_pkg::*;

  logic               valid;
  logic [KEY_BITS-1:0] ekey;
  logic               in_use;
  logic [STAMP_W-1:0] age;
  logic [SIZE_W-1:0]  size;
  logic               sel;

  assign sel = (cmd.target == 8'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && cmd.op == OP_WRITE) begin
      valid <= 1'b1;
    end else if (sel && cmd.op == OP_INVAL) begin
      valid <= 1'b0;
    end
    if (sel && cmd.op == OP_WRITE) begin
      ekey <= wkey;
      size <= cmd.size;
    end
    if (sel && (cmd.op == OP_WRITE || cmd.op == OP_AGE)) begin
      in_use <= cmd.in_use;
      age    <= cmd.age;
    end
  end

  always_comb begin
    tok_out = tok_in;
    if (valid && ekey == key && !tok_in.hit) begin
      tok_out.hit        = 1'b1;
      tok_out.hit_idx    = 8'(IDX);
      tok_out.hit_in_use = in_use;
      tok_out.hit_age    = age;
    end
    if (!valid && !tok_in.free) begin
      tok_out.free     = 1'b1;
      tok_out.free_idx = 8'(IDX);
    end
    if (valid && !in_use && (!tok_in.rel || age < tok_in.rel_stamp)) begin
      tok_out.rel       = 1'b1;
      tok_out.rel_idx   = 8'(IDX);
      tok_out.rel_stamp = age;
      tok_out.rel_size  = size;
    end
  end
endmodule
`default_nettype wire

[design/rcache_chain.sv]
// ----------------------------------------------------------------------------
// rcache_chain
// Row of cells; token is registered every SEG cells.
// ----------------------------------------------------------------------------
`default_nettype none
module rcache_chain #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire [KEY_BITS-1:0]         key,
  input  wire rcache_pkg::cell_cmd_t cmd,
  output rcache_pkg::token_t         tok
);
  import rcache_pkg::*;

  localparam int SEG = 4;
  localparam int NSTG = (ENTRIES + SEG - 1) / SEG;

  token_t link [ENTRIES+1];
  token_t stg  [NSTG+1];

  assign stg[0] = '0;

  genvar g, c;
  generate
    for (g = 0; g < NSTG; g++) begin : g_stage
      token_t head;
      assign head = stg[g];
      for (c = 0; c < SEG; c++) begin : g_cell
        if (g*SEG + c < ENTRIES) begin : g_on
          rcache_cell #(.IDX(g*SEG + c), .KEY_BITS(KEY_BITS)) u_cell (
            .clk(clk), .rst(rst), .key(key), .cmd(cmd), .wkey(key),
            .tok_in((c == 0) ? head : link[g*SEG + c]),
            .tok_out(link[g*SEG + c + 1])
          );
        end
      end
      always_ff @(posedge clk) begin
        stg[g+1] <= link[(g*SEG + SEG < ENTRIES) ? g*SEG + SEG : ENTRIES];
      end
    end
  endgenerate

  assign link[0] = '0;
  assign tok = stg[NSTG];
endmodule
`default_nettype wire

[design/rcache_checker.sv]
// ----------------------------------------------------------------------------
// rcache_checker
// Port-level checks for the release-order cache.
// ----------------------------------------------------------------------------
`default_nettype none
`include "refcounted_cache_release_order_evict_macros.svh"
module rcache_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wire rcache_pkg::out_t out_data
);
  import rcache_pkg::*;

  `RC_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "second beat taken")
  `RC_ASSERT_IMP(a_err_slot, clk, rst, out_valid && (out_data.status == ST_FULL || out_data.status == ST_UNKNOWN), out_data.slot == 4'd0, "slot on error")
  `RC_ASSERT_IMP(a_evict_get, clk, rst, out_valid && out_data.status != ST_INSERT, out_data.evicted_count == 5'd0, "evict without insert")
  `RC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
endmodule

bind refcounted_cache_release_order_evict rcache_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
